>>> rtl/core/vml_pkg.sv
// Shared widths, latencies, types and the limit reset function for the magnitude limiter.
`default_nettype none
package vml_pkg;

  localparam int IN_W = 32;
  localparam int OUT_W = 17;
  localparam int LIM_W = 16;
  localparam int LIM_SQ_W = 2 * LIM_W;
  localparam int SUM_W = 64;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W = ROOT_W + 3;
  localparam int PROD_W = IN_W + LIM_W;
  localparam int Q_W = LIM_W;
  localparam int NUM_LANES = 3;

  localparam int FRONT_LAT = 2;
  localparam int SQRT_LAT = ROOT_W;
  localparam int DIV_LAT = Q_W;
  localparam int PIPE_LAT = FRONT_LAT + 1 + SQRT_LAT + DIV_LAT + 1;

  localparam int FRAC_BITS_DEF = 16;

  // Divisor used on the pass-through path: N = mag << Q_W divided by this gives mag back.
  localparam logic [ROOT_W-1:0] UNITY_DIV = ROOT_W'(64'd1 << Q_W);

  typedef struct packed {
    logic              neg;
    logic [IN_W-1:0]   mag;
    logic [SUM_W-1:0]  sq;
    logic [PROD_W-1:0] prod;
  } front_t;

  typedef struct packed {
    logic [NUM_LANES-1:0] neg;
    logic                 limited;
  } tag_t;

  // round(0.158 * 2^frac_bits), saturated to the register width
  function automatic logic [LIM_W-1:0] limit_reset(input int frac_bits);
    longint unsigned raw;
    raw = ((64'd158 << frac_bits) + 64'd500) / 64'd1000;
    if (raw > 64'(2 ** LIM_W - 1)) begin
      raw = 64'(2 ** LIM_W - 1);
    end
    return LIM_W'(raw);
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/vml_front.sv
// One lane front end: sign split, square and product with the limit.
`default_nettype none
module vml_front
  import vml_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [IN_W-1:0]  comp,
  input  wire logic        [LIM_W-1:0] lim,
  output front_t                       res
);

  logic            neg1;
  logic [IN_W-1:0] mag1;

  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= comp[IN_W-1];
      mag1 <= comp[IN_W-1] ? (IN_W'(0) - IN_W'(comp)) : IN_W'(comp);
      res.neg  <= neg1;
      res.mag  <= mag1;
      res.sq   <= SUM_W'(mag1) * SUM_W'(mag1);
      res.prod <= PROD_W'(mag1) * PROD_W'(lim);
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/vml_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module vml_sqrt
  import vml_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [SUM_W-1:0]  radicand,
  output logic      [ROOT_W-1:0] root
);

  logic [SUM_W-1:0]  rad_q  [1:SQRT_LAT];
  logic [REM_W-1:0]  rem_q  [1:SQRT_LAT];
  logic [ROOT_W-1:0] root_q [1:SQRT_LAT];

  for (genvar i = 0; i < SQRT_LAT; i++) begin : g_stage
    logic [SUM_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    if (i == 0) begin : g_first
      assign rad_in  = radicand;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_rest
      assign rad_in  = rad_q[i];
      assign rem_in  = rem_q[i];
      assign root_in = root_q[i];
    end

    // bring down the next two radicand bits and try root*4+1
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[SUM_W-1 -: 2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[i+1]  <= {rad_in[SUM_W-3:0], 2'b00};
        rem_q[i+1]  <= take ? (rem_sh - trial) : rem_sh;
        root_q[i+1] <= {root_in[ROOT_W-2:0], take};
      end
    end
  end

  assign root = root_q[SQRT_LAT];

endmodule
`default_nettype wire

>>> rtl/core/vml_div.sv
// Pipelined restoring divider, one quotient bit per stage; quotient known to fit Q_W bits.
`default_nettype none
module vml_div
  import vml_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [PROD_W-1:0] dividend,
  input  wire logic [ROOT_W-1:0] divisor,
  output logic      [Q_W-1:0]    quotient
);

  logic [ROOT_W-1:0] rem_q [1:DIV_LAT];
  logic [Q_W-1:0]    low_q [1:DIV_LAT];
  logic [ROOT_W-1:0] dvs_q [1:DIV_LAT];
  logic [Q_W-1:0]    quo_q [1:DIV_LAT];

  for (genvar k = 0; k < DIV_LAT; k++) begin : g_stage
    logic [ROOT_W-1:0] rem_in;
    logic [Q_W-1:0]    low_in;
    logic [ROOT_W-1:0] dvs_in;
    logic [Q_W-1:0]    quo_in;
    logic [ROOT_W:0]   trial;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_in = dividend[PROD_W-1 -: ROOT_W];
      assign low_in = dividend[Q_W-1:0];
      assign dvs_in = divisor;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_q[k];
      assign low_in = low_q[k];
      assign dvs_in = dvs_q[k];
      assign quo_in = quo_q[k];
    end

    assign trial = {rem_in, low_in[Q_W-1]};
    assign take  = trial >= {1'b0, dvs_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= take ? ROOT_W'(trial - {1'b0, dvs_in}) : ROOT_W'(trial);
        low_q[k+1] <= {low_in[Q_W-2:0], 1'b0};
        dvs_q[k+1] <= dvs_in;
        quo_q[k+1] <= {quo_in[Q_W-2:0], take};
      end
    end
  end

  assign quotient = quo_q[DIV_LAT];

endmodule
`default_nettype wire

>>> rtl/core/vector_magnitude_limiter.sv
// Top level: three-lane vector magnitude limiter with sum, square root and merge.
//
//  channel | signals                              | dir
//  --------+--------------------------------------+-----
//  cfg     | cfg_valid cfg_ready cfg_data[15:0]   | in
//  in      | in_valid in_ready x_in y_in z_in     | in
//  out     | out_valid out_ready x/y/z_out limited| out
//
// One request per cycle; the pipeline holds 2 lane front stages, 1 sum stage,
// 32 square-root stages (one root bit each), 16 divider stages (one quotient bit each)
// and the output register. The whole pipeline advances together and holds only when
// the output register is full and not taken. Reset (synchronous) clears the valid
// chain and loads the limit with round(0.158 * 2^FRAC_BITS). cfg_ready is always high.
`default_nettype none
module vector_magnitude_limiter
  import vml_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic        [LIM_W-1:0]  cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [IN_W-1:0]   x_in,
  input  wire logic signed [IN_W-1:0]   y_in,
  input  wire logic signed [IN_W-1:0]   z_in,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed      [OUT_W-1:0]  x_out,
  output logic signed      [OUT_W-1:0]  y_out,
  output logic signed      [OUT_W-1:0]  z_out,
  output logic                          limited
);

  logic [LIM_W-1:0]    current_limit;
  logic [LIM_SQ_W-1:0] lim_sq;
  logic                adv;
  logic [PIPE_LAT-1:0] vld;

  logic signed [IN_W-1:0] comp [NUM_LANES];
  front_t                 fr   [NUM_LANES];

  logic [SUM_W-1:0]  sum_c;
  logic              over_c;
  logic [SUM_W-1:0]  sum3;
  tag_t              tag3;
  logic [PROD_W-1:0] n3    [NUM_LANES];
  logic [PROD_W-1:0] n_d   [NUM_LANES][SQRT_LAT];
  tag_t              tag_d [SQRT_LAT + DIV_LAT];
  logic [ROOT_W-1:0] root;
  logic [ROOT_W-1:0] divisor;
  logic [Q_W-1:0]    quo   [NUM_LANES];
  logic [OUT_W-1:0]  res   [NUM_LANES];

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      current_limit <= limit_reset(FRAC_BITS);
    end else if (cfg_valid && cfg_ready) begin
      current_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    lim_sq <= LIM_SQ_W'(current_limit) * LIM_SQ_W'(current_limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_LAT-2:0], in_valid};
    end
  end

  assign comp[0] = x_in;
  assign comp[1] = y_in;
  assign comp[2] = z_in;

  for (genvar j = 0; j < NUM_LANES; j++) begin : g_front
    vml_front u_front (
      .clk  (clk),
      .en   (adv),
      .comp (comp[j]),
      .lim  (current_limit),
      .res  (fr[j])
    );
  end

  assign sum_c  = fr[0].sq + fr[1].sq + fr[2].sq;
  assign over_c = sum_c > SUM_W'(lim_sq);

  // pick the numerator: scaled product when limiting, mag << Q_W to pass through
  always_ff @(posedge clk) begin
    if (adv) begin
      sum3         <= sum_c;
      tag3.limited <= over_c;
      for (int j = 0; j < NUM_LANES; j++) begin
        tag3.neg[j] <= fr[j].neg;
        n3[j]       <= over_c ? fr[j].prod : PROD_W'({fr[j].mag[Q_W-1:0], Q_W'(0)});
      end
    end
  end

  vml_sqrt u_sqrt (
    .clk      (clk),
    .en       (adv),
    .radicand (sum3),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_d[0] <= tag3;
      for (int k = 1; k < SQRT_LAT + DIV_LAT; k++) begin
        tag_d[k] <= tag_d[k-1];
      end
      for (int j = 0; j < NUM_LANES; j++) begin
        n_d[j][0] <= n3[j];
        for (int k = 1; k < SQRT_LAT; k++) begin
          n_d[j][k] <= n_d[j][k-1];
        end
      end
    end
  end

  assign divisor = tag_d[SQRT_LAT-1].limited ? root : UNITY_DIV;

  for (genvar j = 0; j < NUM_LANES; j++) begin : g_div
    vml_div u_div (
      .clk      (clk),
      .en       (adv),
      .dividend (n_d[j][SQRT_LAT-1]),
      .divisor  (divisor),
      .quotient (quo[j])
    );

    assign res[j] = tag_d[SQRT_LAT+DIV_LAT-1].neg[j] ?
                    (OUT_W'(0) - OUT_W'(quo[j])) : OUT_W'(quo[j]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x_out   <= res[0];
      y_out   <= res[1];
      z_out   <= res[2];
      limited <= tag_d[SQRT_LAT+DIV_LAT-1].limited;
    end
  end

`ifndef SYNTHESIS
  // the delivered x component stays within the limit in size
  a_within_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((x_out[OUT_W-1] ? (OUT_W'(0) - x_out) : x_out) <= {1'b0, current_limit}))
    else $error("x_out exceeds current_limit");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a blocked output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule
`default_nettype wire
